[sv/tph_pkg.sv]
// shared types and widths for the plane height core
package tph_pkg;

    localparam int CoordW = 32;          // one coordinate field
    localparam int DiffW  = 33;          // difference of two coordinates
    localparam int ProdW  = 66;          // product of two differences
    localparam int NormW  = 67;          // normal component
    localparam int SplitW = 34;          // low part of a normal component
    localparam int LoW    = 68;          // low partial product
    localparam int HiW    = 66;          // high partial product
    localparam int NumW   = 102;         // numerator of the quotient
    localparam int QuoW   = 34;          // quotient bits kept before saturation
    localparam int RemW   = 67;          // remainder width

    typedef struct packed {
        logic signed [CoordW-1:0] a_x;
        logic signed [CoordW-1:0] a_y;
        logic signed [CoordW-1:0] a_z;
        logic signed [CoordW-1:0] b_x;
        logic signed [CoordW-1:0] b_y;
        logic signed [CoordW-1:0] b_z;
        logic signed [CoordW-1:0] c_x;
        logic signed [CoordW-1:0] c_y;
        logic signed [CoordW-1:0] c_z;
        logic signed [CoordW-1:0] query_x;
        logic signed [CoordW-1:0] query_y;
    } tph_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] height;
        logic                     vertical_plane;
    } tph_out_t;

    // one stage of the restoring divider
    typedef struct packed {
        logic [RemW-1:0]          rem;
        logic [QuoW-1:0]          nlo;
        logic [NormW-1:0]         nb;
        logic [QuoW-1:0]          q;
        logic                     neg;
        logic                     ovf;
        logic                     vert;
        logic signed [CoordW-1:0] az;
    } tph_div_t;

endpackage

[sv/triangle_plane_height_core.sv]
// plane height from three triangle corners, fully pipelined
//
// in_valid/in_ready carry one transaction per query: corners a, b, c and the
// query point, all signed fixed point. out_valid/out_ready return one
// transaction per query in the same order: the plane height at the query
// point, saturated to 32 bits, or vertical_plane set and height zero when the
// normal has no z component.
// from acceptance to out_valid a transaction passes eight arithmetic stages
// (differences, products, normal, split multiply, two adds, magnitude and
// range check), 34 restoring divider stages, one bit each, and the output
// register; the first stage loads at the accepting edge. one transaction
// enters every cycle unless frozen; the divider chain is what sets the depth.
// reset clears all valid bits; data registers are not reset.
// when the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated, and
// empty stages still accept new transactions while out_valid is low.
module triangle_plane_height_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tph_pkg::tph_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tph_pkg::tph_out_t out_data
);
    import tph_pkg::*;

    localparam int NStage = 8 + QuoW;   // stages before the output register

    logic              en;
    logic [NStage-1:0] valid_reg;
    logic              out_valid_reg;
    tph_out_t          out_data_reg;

    // stage 1: differences
    logic signed [DiffW-1:0]  ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [DiffW-1:0]  dqx_reg, dqy_reg;
    logic signed [CoordW-1:0] az1_reg;
    // stage 2: products
    logic signed [ProdW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DiffW-1:0]  dqx2_reg, dqy2_reg;
    logic signed [CoordW-1:0] az2_reg;
    // stage 3: normal
    logic signed [NormW-1:0]  nx_reg, ny_reg, nz_reg;
    logic signed [DiffW-1:0]  dqx3_reg, dqy3_reg;
    logic signed [CoordW-1:0] az3_reg;
    // stage 4: split partial products
    logic signed [LoW-1:0]    xlo_reg, ylo_reg;
    logic signed [HiW-1:0]    xhi_reg, yhi_reg;
    logic signed [NormW-1:0]  nz4_reg;
    logic signed [CoordW-1:0] az4_reg;
    // stage 5: per-axis terms
    logic signed [NumW-1:0]   tx_reg, ty_reg;
    logic signed [NormW-1:0]  nz5_reg;
    logic signed [CoordW-1:0] az5_reg;
    // stage 6: numerator
    logic signed [NumW-1:0]   num_reg;
    logic signed [NormW-1:0]  nz6_reg;
    logic signed [CoordW-1:0] az6_reg;
    // stage 7: magnitudes
    logic [NumW-1:0]          na_reg;
    logic [NormW-1:0]         nb_reg;
    logic                     neg7_reg, vert7_reg;
    logic signed [CoordW-1:0] az7_reg;
    // stage 8 and the divider
    tph_div_t                 div_reg [0:QuoW];

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[NStage-2:0], in_valid};
            out_valid_reg <= valid_reg[NStage-1];
        end
    end

    // arithmetic front end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg  <= DiffW'(in_data.c_x) - DiffW'(in_data.a_x);
            uy_reg  <= DiffW'(in_data.c_y) - DiffW'(in_data.a_y);
            uz_reg  <= DiffW'(in_data.c_z) - DiffW'(in_data.a_z);
            vx_reg  <= DiffW'(in_data.b_x) - DiffW'(in_data.a_x);
            vy_reg  <= DiffW'(in_data.b_y) - DiffW'(in_data.a_y);
            vz_reg  <= DiffW'(in_data.b_z) - DiffW'(in_data.a_z);
            dqx_reg <= DiffW'(in_data.a_x) - DiffW'(in_data.query_x);
            dqy_reg <= DiffW'(in_data.a_y) - DiffW'(in_data.query_y);
            az1_reg <= in_data.a_z;

            p0_reg   <= uy_reg * vz_reg;
            p1_reg   <= uz_reg * vy_reg;
            p2_reg   <= uz_reg * vx_reg;
            p3_reg   <= ux_reg * vz_reg;
            p4_reg   <= ux_reg * vy_reg;
            p5_reg   <= uy_reg * vx_reg;
            dqx2_reg <= dqx_reg;
            dqy2_reg <= dqy_reg;
            az2_reg  <= az1_reg;

            nx_reg   <= NormW'(p0_reg) - NormW'(p1_reg);
            ny_reg   <= NormW'(p2_reg) - NormW'(p3_reg);
            nz_reg   <= NormW'(p4_reg) - NormW'(p5_reg);
            dqx3_reg <= dqx2_reg;
            dqy3_reg <= dqy2_reg;
            az3_reg  <= az2_reg;

            // normal split into unsigned low and signed high halves
            xlo_reg <= $signed({1'b0, nx_reg[SplitW-1:0]}) * dqx3_reg;
            xhi_reg <= $signed(nx_reg[NormW-1:SplitW]) * dqx3_reg;
            ylo_reg <= $signed({1'b0, ny_reg[SplitW-1:0]}) * dqy3_reg;
            yhi_reg <= $signed(ny_reg[NormW-1:SplitW]) * dqy3_reg;
            nz4_reg <= nz_reg;
            az4_reg <= az3_reg;

            tx_reg  <= NumW'(xlo_reg) + $signed({xhi_reg[HiW-1], xhi_reg[HiW-1], xhi_reg,
                                                   {SplitW{1'b0}}});
            ty_reg  <= NumW'(ylo_reg) + $signed({yhi_reg[HiW-1], yhi_reg[HiW-1], yhi_reg,
                                                   {SplitW{1'b0}}});
            nz5_reg <= nz4_reg;
            az5_reg <= az4_reg;

            num_reg <= tx_reg + ty_reg;
            nz6_reg <= nz5_reg;
            az6_reg <= az5_reg;

            na_reg    <= num_reg[NumW-1] ? NumW'(-num_reg) : NumW'(num_reg);
            nb_reg    <= nz6_reg[NormW-1] ? NormW'(-nz6_reg) : NormW'(nz6_reg);
            neg7_reg  <= num_reg[NumW-1] ^ nz6_reg[NormW-1];
            vert7_reg <= (nz6_reg == '0);
            az7_reg   <= az6_reg;

            // quotient too large for the kept bits saturates outright
            div_reg[0].ovf  <= (na_reg[NumW-1:QuoW] >= {1'b0, nb_reg});
            div_reg[0].rem  <= na_reg[NumW-2:QuoW];
            div_reg[0].nlo  <= na_reg[QuoW-1:0];
            div_reg[0].nb   <= nb_reg;
            div_reg[0].q    <= '0;
            div_reg[0].neg  <= neg7_reg;
            div_reg[0].vert <= vert7_reg;
            div_reg[0].az   <= az7_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < QuoW; i++)
    begin : g_div
        logic [RemW:0]  trial;
        logic           fits;
        tph_div_t       nxt;

        always_comb
        begin
            trial   = {div_reg[i].rem, div_reg[i].nlo[QuoW-1]};
            fits    = (trial >= {1'b0, div_reg[i].nb});
            nxt     = div_reg[i];
            nxt.rem = fits ? RemW'(trial - {1'b0, div_reg[i].nb}) : RemW'(trial);
            nxt.nlo = {div_reg[i].nlo[QuoW-2:0], 1'b0};
            nxt.q   = {div_reg[i].q[QuoW-2:0], fits};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[i+1] <= nxt;
            end
        end
    end

    // sign, add a_z, saturate
    logic signed [QuoW:0]   qs;
    logic signed [QuoW+1:0] hsum;
    tph_out_t               res_next;

    always_comb
    begin
        qs   = div_reg[QuoW].neg ? -$signed({1'b0, div_reg[QuoW].q})
                                 :  $signed({1'b0, div_reg[QuoW].q});
        hsum = (QuoW+2)'(div_reg[QuoW].az) + (QuoW+2)'(qs);
        res_next.vertical_plane = 1'b0;
        if (div_reg[QuoW].vert)
        begin
            res_next.height         = '0;
            res_next.vertical_plane = 1'b1;
        end
        else if (div_reg[QuoW].ovf)
        begin
            res_next.height = div_reg[QuoW].neg ? {1'b1, {(CoordW-1){1'b0}}}
                                                : {1'b0, {(CoordW-1){1'b1}}};
        end
        else if (hsum[QuoW+1:CoordW-1] != {(QuoW-CoordW+3){hsum[QuoW+1]}})
        begin
            res_next.height = hsum[QuoW+1] ? {1'b1, {(CoordW-1){1'b0}}}
                                           : {1'b0, {(CoordW-1){1'b1}}};
        end
        else
        begin
            res_next.height = hsum[CoordW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res_next;
        end
    end

    // checks
    a_vert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.vertical_plane |-> out_data.height == '0)
        else $error("vertical plane with nonzero height");

    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !(|valid_reg) && !out_valid |=> !out_valid)
        else $error("result from an empty pipeline");

    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[NStage-1]))
        else $error("out_valid rose without a last-stage transaction");

endmodule
